// File: design/ffa_pkg.sv
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared types and constants for the first-fit segment allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffa_pkg;

  // Heap and table geometry
  localparam int HEAP_SIZE    = 4096;
  localparam int MAX_SEGMENTS = 64;
  localparam int IDX_W        = $clog2(MAX_SEGMENTS);
  localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);

  // Field widths
  localparam int ADDR_W = 12;
  localparam int SIZE_W = 13;

  // Request codes
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // One table entry
  typedef struct packed {
    logic              used;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] start;
  } seg_t;

  // Write request into the segment table
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    seg_t             data;
  } seg_wr_t;

  // Contents of entry 0 after reset: one free segment spanning the heap
  localparam seg_t SEG_RESET = '{used: 1'b0, size: SIZE_W'(HEAP_SIZE), start: '0};

endpackage

`default_nettype wire

// File: design/ffa_seg_table.sv
// ----------------------------------------------------------------------------
// ffa_seg_table
// Segment table memory: one write port, one read port with registered data.
// Entry 0 reads as the whole-heap segment until it is first written.
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_seg_table (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic [ffa_pkg::IDX_W-1:0] rd_idx_i,
  output ffa_pkg::seg_t                rd_data_o,
  input  wire ffa_pkg::seg_wr_t        wr_i
);
  import ffa_pkg::*;

  seg_t mem [MAX_SEGMENTS];
  seg_t rd_q;
  logic v0_q;
  logic rd_init_q;

  // Storage and registered read
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.idx] <= wr_i.data;
    end
    rd_q <= mem[rd_idx_i];
  end

  // Entry 0 written flag and reset-value select for the read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q      <= 1'b0;
      rd_init_q <= 1'b0;
    end else begin
      rd_init_q <= (rd_idx_i == '0) && !v0_q;
      if (wr_i.en && (wr_i.idx == '0)) begin
        v0_q <= 1'b1;
      end
    end
  end

  assign rd_data_o = rd_init_q ? SEG_RESET : rd_q;

endmodule

`default_nettype wire

// File: design/first_fit_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_allocator
// First-fit heap allocator over an address-ordered table of segments.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake                 fields
//   in       input      in_valid_i / in_stall_o   mode_i, req_size_i, address_i
//   out      output     out_valid_o / out_stall_i block_address_o, ok_o
//
// One item at a time; the table memory, read one entry per cycle, sets the pace.
// A miss scans every entry; an allocate that splits and a free that merges also
// move the entries behind the changed one, one place up or down.
// Reset leaves one free segment over the heap. A new item is taken while the
// last result still waits on out_stall_i; the next result then holds in ST_DONE.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_allocator (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic                     mode_i,
  input  wire logic [ffa_pkg::SIZE_W-1:0] req_size_i,
  input  wire logic [ffa_pkg::ADDR_W-1:0] address_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic [ffa_pkg::ADDR_W-1:0]    block_address_o,
  output logic                          ok_o
);
  import ffa_pkg::*;

  // Sequencer states
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SCAN = 4'd1;
  localparam logic [3:0] ST_MOVE = 4'd2;
  localparam logic [3:0] ST_AWR0 = 4'd3;
  localparam logic [3:0] ST_AWR1 = 4'd4;
  localparam logic [3:0] ST_FRDN = 4'd5;
  localparam logic [3:0] ST_FNXT = 4'd6;
  localparam logic [3:0] ST_FPRV = 4'd7;
  localparam logic [3:0] ST_DONE = 4'd8;

  logic [3:0]        state_q, state_d;
  logic              mode_q, mode_d;
  logic [SIZE_W-1:0] req_q, req_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  ptr_q, ptr_d;
  logic              dv_q, dv_d;
  logic [IDX_W-1:0]  cidx_q, cidx_d;
  logic [IDX_W-1:0]  k_q, k_d;
  seg_t              cur_q, cur_d;
  seg_t              prv_q, prv_d;
  logic              split_q, split_d;
  logic              res_ok_q, res_ok_d;
  logic [IDX_W-1:0]  mv_src_q, mv_src_d;
  logic [IDX_W-1:0]  mv_dst_q, mv_dst_d;
  logic [CNT_W-1:0]  mv_left_q, mv_left_d;
  logic              mv_up_q, mv_up_d;
  logic              mv_pend_q, mv_pend_d;
  logic [3:0]        mv_ret_q, mv_ret_d;
  logic              out_valid_q, out_valid_d;
  logic [ADDR_W-1:0] out_addr_q, out_addr_d;
  logic              out_ok_q, out_ok_d;

  logic [IDX_W-1:0]  rd_idx;
  seg_t              rdat;
  seg_wr_t           wr;

  logic              hit;
  logic [SIZE_W-1:0] scan_left;
  logic [SIZE_W-1:0] cur_left;
  seg_t              merged;

  // Segment table
  ffa_seg_table u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_idx_i (rd_idx),
    .rd_data_o(rdat),
    .wr_i     (wr)
  );

  // Entry match for the scanned entry
  assign hit = (mode_q == MODE_ALLOC) ? (!rdat.used && (rdat.size >= req_q))
                                      : (rdat.start == addr_q);
  assign scan_left = rdat.size - req_q;
  assign cur_left  = cur_q.size - req_q;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    req_d       = req_q;
    addr_d      = addr_q;
    cnt_d       = cnt_q;
    ptr_d       = ptr_q;
    dv_d        = 1'b0;
    cidx_d      = cidx_q;
    k_d         = k_q;
    cur_d       = cur_q;
    prv_d       = prv_q;
    split_d     = split_q;
    res_ok_d    = res_ok_q;
    mv_src_d    = mv_src_q;
    mv_dst_d    = mv_dst_q;
    mv_left_d   = mv_left_q;
    mv_up_d     = mv_up_q;
    mv_pend_d   = 1'b0;
    mv_ret_d    = mv_ret_q;
    out_valid_d = out_valid_q;
    out_addr_d  = out_addr_q;
    out_ok_d    = out_ok_q;
    rd_idx      = '0;
    wr          = '0;
    merged      = cur_q;

    // Result taken downstream
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          mode_d  = mode_i;
          req_d   = req_size_i;
          addr_d  = address_i;
          ptr_d   = '0;
          state_d = ST_SCAN;
        end
      end

      // Read one entry per cycle, check the one read last cycle
      ST_SCAN: begin
        if (ptr_q < cnt_q) begin
          rd_idx = ptr_q[IDX_W-1:0];
          ptr_d  = ptr_q + CNT_W'(1);
          dv_d   = 1'b1;
          cidx_d = ptr_q[IDX_W-1:0];
        end
        if (dv_q) begin
          if (hit) begin
            dv_d     = 1'b0;
            k_d      = cidx_q;
            res_ok_d = 1'b1;
            if (mode_q == MODE_ALLOC) begin
              cur_d   = rdat;
              split_d = (scan_left > SIZE_W'(1)) && (cnt_q < CNT_W'(MAX_SEGMENTS));
              // open a hole at cidx+1 by moving the tail up one place
              mv_up_d   = 1'b1;
              mv_src_d  = IDX_W'(cnt_q - CNT_W'(1));
              mv_left_d = ((scan_left > SIZE_W'(1)) && (cnt_q < CNT_W'(MAX_SEGMENTS)))
                          ? (cnt_q - CNT_W'(1) - CNT_W'(cidx_q)) : '0;
              mv_ret_d  = ST_AWR0;
              state_d   = ST_MOVE;
            end else begin
              cur_d      = rdat;
              cur_d.used = 1'b0;
              state_d    = ST_FRDN;
            end
          end else begin
            prv_d = rdat;
            if (CNT_W'(cidx_q) == (cnt_q - CNT_W'(1))) begin
              dv_d     = 1'b0;
              res_ok_d = 1'b0;
              state_d  = ST_DONE;
            end
          end
        end
      end

      // Move a run of entries one place up or down, one entry per cycle
      ST_MOVE: begin
        if (mv_pend_q) begin
          wr.en   = 1'b1;
          wr.idx  = mv_dst_q;
          wr.data = rdat;
        end
        if (mv_left_q != '0) begin
          rd_idx    = mv_src_q;
          mv_src_d  = mv_up_q ? (mv_src_q - IDX_W'(1)) : (mv_src_q + IDX_W'(1));
          mv_dst_d  = mv_up_q ? (mv_src_q + IDX_W'(1)) : (mv_src_q - IDX_W'(1));
          mv_left_d = mv_left_q - CNT_W'(1);
          mv_pend_d = 1'b1;
        end else if (!mv_pend_q) begin
          state_d = mv_ret_q;
        end
      end

      // Mark the chosen segment used, cut it when splitting
      ST_AWR0: begin
        wr.en         = 1'b1;
        wr.idx        = k_q;
        wr.data.used  = 1'b1;
        wr.data.size  = split_q ? req_q : cur_q.size;
        wr.data.start = cur_q.start;
        state_d       = split_q ? ST_AWR1 : ST_DONE;
      end

      // Free remainder after the allocated part
      ST_AWR1: begin
        wr.en         = 1'b1;
        wr.idx        = k_q + IDX_W'(1);
        wr.data.used  = 1'b0;
        wr.data.size  = cur_left;
        wr.data.start = cur_q.start + ADDR_W'(req_q);
        cnt_d         = cnt_q + CNT_W'(1);
        state_d       = ST_DONE;
      end

      // Fetch the next neighbor if there is one
      ST_FRDN: begin
        if ((CNT_W'(k_q) + CNT_W'(1)) < cnt_q) begin
          rd_idx  = k_q + IDX_W'(1);
          state_d = ST_FNXT;
        end else begin
          wr.en   = 1'b1;
          wr.idx  = k_q;
          wr.data = cur_q;
          state_d = ST_FPRV;
        end
      end

      // Merge with a free next neighbor
      ST_FNXT: begin
        wr.en  = 1'b1;
        wr.idx = k_q;
        if (!rdat.used) begin
          merged.size = cur_q.size + rdat.size;
          cur_d       = merged;
          wr.data     = merged;
          mv_up_d     = 1'b0;
          mv_src_d    = k_q + IDX_W'(2);
          mv_left_d   = cnt_q - CNT_W'(k_q) - CNT_W'(2);
          mv_ret_d    = ST_FPRV;
          cnt_d       = cnt_q - CNT_W'(1);
          state_d     = ST_MOVE;
        end else begin
          wr.data = cur_q;
          state_d = ST_FPRV;
        end
      end

      // Merge into a free previous neighbor
      ST_FPRV: begin
        if ((k_q != '0) && !prv_q.used) begin
          wr.en        = 1'b1;
          wr.idx       = k_q - IDX_W'(1);
          wr.data      = prv_q;
          wr.data.size = prv_q.size + cur_q.size;
          mv_up_d      = 1'b0;
          mv_src_d     = k_q + IDX_W'(1);
          mv_left_d    = cnt_q - CNT_W'(k_q) - CNT_W'(1);
          mv_ret_d     = ST_DONE;
          cnt_d        = cnt_q - CNT_W'(1);
          state_d      = ST_MOVE;
        end else begin
          state_d = ST_DONE;
        end
      end

      // Hand the result to the output register
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_ok_d    = res_ok_q;
          out_addr_d  = ((mode_q == MODE_ALLOC) && res_ok_q) ? cur_q.start : '0;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= CNT_W'(1);
      dv_q        <= 1'b0;
      mv_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      dv_q        <= dv_d;
      mv_pend_q   <= mv_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working and payload registers
  always_ff @(posedge clk_i) begin
    mode_q     <= mode_d;
    req_q      <= req_d;
    addr_q     <= addr_d;
    ptr_q      <= ptr_d;
    cidx_q     <= cidx_d;
    k_q        <= k_d;
    cur_q      <= cur_d;
    prv_q      <= prv_d;
    split_q    <= split_d;
    res_ok_q   <= res_ok_d;
    mv_src_q   <= mv_src_d;
    mv_dst_q   <= mv_dst_d;
    mv_left_q  <= mv_left_d;
    mv_up_q    <= mv_up_d;
    mv_ret_q   <= mv_ret_d;
    out_addr_q <= out_addr_d;
    out_ok_q   <= out_ok_d;
  end

  assign in_stall_o      = (state_q != ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign block_address_o = out_addr_q;
  assign ok_o            = out_ok_q;

endmodule

`default_nettype wire

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the first-fit segment allocator. A shadow table of
// segments predicts each reply (block address and ok flag) at input
// acceptance. A monitor compares every reply against the oldest prediction.
// Stimulus runs in this order: directed corner cases, a full-table fill and
// drain, an output hold, sender pauses, and a long random mix of allocate and
// free traffic. Both sides idle and stall at random.
// ----------------------------------------------------------------------------

module testbench;
  import ffa_pkg::*;

  localparam int CLK_HALF       = 4;
  localparam int RESET_CYCLES   = 12;
  localparam int RANDOM_ITEMS   = 520;
  localparam int LONG_HOLD      = 400;
  localparam int SETTLE_CYCLES  = 2 * MAX_SEGMENTS + 40;
  localparam int WATCHDOG_LIMIT = 4000;

  // One expected reply
  typedef struct {
    bit [ADDR_W-1:0] block_address;
    bit              ok;
  } alloc_reply_t;

  // DUT signals, inputs all known from time zero
  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  logic              mode_i      = MODE_ALLOC;
  logic [SIZE_W-1:0] req_size_i  = '0;
  logic [ADDR_W-1:0] address_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [ADDR_W-1:0] block_address_o;
  logic              ok_o;

  // Shadow segment table
  bit [ADDR_W-1:0] blk_start [MAX_SEGMENTS];
  bit [SIZE_W-1:0] blk_len   [MAX_SEGMENTS];
  bit              blk_taken [MAX_SEGMENTS];
  int              blk_count;

  alloc_reply_t pending_replies [$];

  // Traffic shaping
  bit tx_steady     = 1'b0;
  bit rx_steady     = 1'b0;
  bit hold_request  = 1'b0;
  int stall_left    = 0;

  // Statistics
  int mismatches      = 0;
  int items_sent      = 0;
  int results_checked = 0;
  int grants          = 0;
  int refusals        = 0;
  int frees_found     = 0;
  int frees_missed    = 0;
  int splits          = 0;
  int merges          = 0;
  int full_grants     = 0;
  int long_holds      = 0;

  first_fit_allocator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .mode_i          (mode_i),
    .req_size_i      (req_size_i),
    .address_i       (address_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .block_address_o (block_address_o),
    .ok_o            (ok_o)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // Idle length: mostly none or short, now and then long
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Request size: mostly small, some large, a few oversized or zero
  function automatic bit [SIZE_W-1:0] draw_req_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 2)  return '0;
    if (r < 70) return SIZE_W'($urandom_range(1, 48));
    if (r < 90) return SIZE_W'($urandom_range(49, 400));
    if (r < 97) return SIZE_W'($urandom_range(401, HEAP_SIZE));
    return SIZE_W'($urandom_range(HEAP_SIZE + 1, (1 << SIZE_W) - 1));
  endfunction

  // Fold entry k+1 into entry k and close the gap
  function automatic void blk_join(int k);
    int j;
    blk_len[k] = blk_len[k] + blk_len[k+1];
    for (j = k + 1; j + 1 < blk_count; j++) begin
      blk_start[j] = blk_start[j+1];
      blk_len[j]   = blk_len[j+1];
      blk_taken[j] = blk_taken[j+1];
    end
    blk_count--;
    merges++;
  endfunction

  // Apply one request to the shadow table and return the expected reply
  function automatic alloc_reply_t heap_predict(bit mode, bit [SIZE_W-1:0] req,
                                                bit [ADDR_W-1:0] addr);
    alloc_reply_t reply;
    int hit;
    int k;
    bit [SIZE_W-1:0] left;
    reply.block_address = '0;
    reply.ok = 1'b0;
    hit = -1;
    if (mode == MODE_ALLOC) begin
      for (k = 0; k < blk_count && hit < 0; k++)
        if (!blk_taken[k] && blk_len[k] >= req) hit = k;
      if (hit < 0) begin
        refusals++;
      end else begin
        blk_taken[hit] = 1'b1;
        left = blk_len[hit] - req;
        if (left > 1 && blk_count < MAX_SEGMENTS) begin
          // split: free remainder goes right after the granted segment
          for (k = blk_count; k > hit + 1; k--) begin
            blk_start[k] = blk_start[k-1];
            blk_len[k]   = blk_len[k-1];
            blk_taken[k] = blk_taken[k-1];
          end
          blk_len[hit]     = req;
          blk_start[hit+1] = ADDR_W'(blk_start[hit] + req);
          blk_len[hit+1]   = left;
          blk_taken[hit+1] = 1'b0;
          blk_count++;
          splits++;
        end else if (left > 1) begin
          full_grants++;
        end
        reply.block_address = blk_start[hit];
        reply.ok = 1'b1;
        grants++;
      end
    end else begin
      for (k = 0; k < blk_count && hit < 0; k++)
        if (blk_start[k] == addr) hit = k;
      if (hit < 0) begin
        frees_missed++;
      end else begin
        blk_taken[hit] = 1'b0;
        if (hit + 1 < blk_count && !blk_taken[hit+1]) blk_join(hit);
        if (hit > 0 && !blk_taken[hit-1]) blk_join(hit - 1);
        reply.ok = 1'b1;
        frees_found++;
      end
    end
    return reply;
  endfunction

  // Offer one item and hold it until accepted; predict on acceptance
  task automatic send_item(input logic mode, input logic [SIZE_W-1:0] req,
                           input logic [ADDR_W-1:0] addr);
    int gap;
    gap = tx_steady ? 0 : draw_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= mode;
    req_size_i <= req;
    address_i  <= addr;
    do @(posedge clk_i); while (in_stall_o);
    pending_replies.push_back(heap_predict(mode, req, addr));
    items_sent++;
  endtask

  // Field extremes, failures, splits, both merges, leftover of one unit
  task automatic test_directed_cases();
    send_item(MODE_ALLOC, SIZE_W'((1 << SIZE_W) - 1), ADDR_W'($urandom));
    send_item(MODE_ALLOC, SIZE_W'(HEAP_SIZE + 1), ADDR_W'($urandom));
    send_item(MODE_ALLOC, '0, ADDR_W'($urandom));
    send_item(MODE_FREE, SIZE_W'($urandom), '0);
    send_item(MODE_ALLOC, SIZE_W'(HEAP_SIZE), ADDR_W'($urandom));
    send_item(MODE_ALLOC, SIZE_W'(1), ADDR_W'($urandom));
    send_item(MODE_FREE, SIZE_W'($urandom), '1);
    send_item(MODE_FREE, SIZE_W'($urandom), '0);
    send_item(MODE_FREE, SIZE_W'($urandom), '0);
    send_item(MODE_ALLOC, SIZE_W'(HEAP_SIZE - 1), ADDR_W'($urandom));
    send_item(MODE_FREE, SIZE_W'($urandom), '0);
    send_item(MODE_ALLOC, SIZE_W'(100), ADDR_W'($urandom));
    send_item(MODE_ALLOC, SIZE_W'(200), ADDR_W'($urandom));
    send_item(MODE_ALLOC, SIZE_W'(300), ADDR_W'($urandom));
    send_item(MODE_FREE, SIZE_W'($urandom), ADDR_W'(100));
    send_item(MODE_ALLOC, SIZE_W'(150), ADDR_W'($urandom));
    send_item(MODE_FREE, SIZE_W'($urandom), ADDR_W'(100));
    send_item(MODE_FREE, SIZE_W'($urandom), ADDR_W'(0));
    send_item(MODE_FREE, SIZE_W'($urandom), ADDR_W'(300));
    send_item(MODE_ALLOC, SIZE_W'(2048), ADDR_W'($urandom));
    send_item(MODE_ALLOC, SIZE_W'(2047), ADDR_W'($urandom));
    send_item(MODE_FREE, SIZE_W'($urandom), ADDR_W'(2048));
    send_item(MODE_FREE, SIZE_W'($urandom), ADDR_W'(0));
  endtask

  // Fill the table with small segments, overflow it, then free everything
  task automatic test_table_full();
    bit [ADDR_W-1:0] held [$];
    int k;
    for (k = 0; k < MAX_SEGMENTS && blk_count < MAX_SEGMENTS; k++)
      send_item(MODE_ALLOC, SIZE_W'(2), ADDR_W'($urandom));
    send_item(MODE_ALLOC, SIZE_W'(2), ADDR_W'($urandom));
    send_item(MODE_ALLOC, SIZE_W'(1), ADDR_W'($urandom));
    for (k = 0; k < blk_count; k++)
      if (blk_taken[k]) held.push_back(blk_start[k]);
    // odd ones first leave isolated holes, evens then merge both ways
    for (k = 1; k < held.size(); k += 2)
      send_item(MODE_FREE, SIZE_W'($urandom), held[k]);
    for (k = 0; k < held.size(); k += 2)
      send_item(MODE_FREE, SIZE_W'($urandom), held[k]);
  endtask

  // Receiver holds off for a long stretch while items keep coming
  task automatic test_output_hold();
    int k;
    tx_steady = 1'b1;
    hold_request = 1'b1;
    for (k = 0; k < 10; k++)
      send_item(MODE_ALLOC, SIZE_W'($urandom_range(1, 32)), ADDR_W'($urandom));
    tx_steady = 1'b0;
  endtask

  // Sender stops until every pending reply has come back
  task automatic test_sender_pause();
    int round;
    int k;
    for (round = 0; round < 2; round++) begin
      for (k = 0; k < 5; k++)
        send_item(MODE_ALLOC, draw_req_size(), ADDR_W'($urandom));
      send_item(MODE_FREE, SIZE_W'($urandom), blk_start[$urandom_range(0, blk_count - 1)]);
      in_valid_i <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clk_i);
    end
  endtask

  // Alternating fill and drain phases with random content
  task automatic test_random_traffic();
    int n;
    bit filling;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 60 == 0) begin
        tx_steady = ($urandom_range(0, 3) == 0);
        rx_steady = ($urandom_range(0, 3) == 0);
      end
      filling = ((n / 60) % 2 == 0);
      if ($urandom_range(0, 99) < (filling ? 70 : 30))
        send_item(MODE_ALLOC, draw_req_size(), ADDR_W'($urandom));
      else if ($urandom_range(0, 99) < 85)
        send_item(MODE_FREE, SIZE_W'($urandom),
                  blk_start[$urandom_range(0, blk_count - 1)]);
      else
        send_item(MODE_FREE, SIZE_W'($urandom), ADDR_W'($urandom));
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  // Receiver: random stalls, plus a long hold on request
  always @(posedge clk_i) begin
    if (hold_request) begin
      stall_left = LONG_HOLD;
      hold_request = 1'b0;
      long_holds++;
    end else if (stall_left == 0 && !rx_steady && $urandom_range(0, 3) == 0) begin
      stall_left = draw_gap();
    end
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Reply checker
  always @(posedge clk_i) begin
    alloc_reply_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      results_checked++;
      if (pending_replies.size() == 0) begin
        $error("unexpected item: block_address %0d ok %0b", block_address_o, ok_o);
        mismatches++;
      end else begin
        want = pending_replies.pop_front();
        if (block_address_o !== want.block_address) begin
          $error("block_address: expected %0d, got %0d", want.block_address,
                 block_address_o);
          mismatches++;
        end
        if (ok_o !== want.ok) begin
          $error("ok: expected %0b, got %0b", want.ok, ok_o);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: too long without any handshake on either side
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // Main sequence
  initial begin
    blk_count    = 1;
    blk_start[0] = '0;
    blk_len[0]   = SIZE_W'(HEAP_SIZE);
    blk_taken[0] = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_table_full();
    test_output_hold();
    test_sender_pause();
    test_random_traffic();

    in_valid_i <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Checked %0d replies to %0d requests: %0d grants, %0d refusals, %0d frees found, %0d unknown frees.",
             results_checked, items_sent, grants, refusals, frees_found, frees_missed);
    $display("Table activity: %0d splits, %0d merges, %0d whole grants on a full table, %0d long holds.",
             splits, merges, full_grants, long_holds);
    if (mismatches == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
